/* rtl/imei_pkg.sv */
// Shared constants, types and the prefix table for the IMEI stream validator.
`timescale 1ns / 1ps

package imei_pkg;

    localparam int IMEI_DIGITS_DEF = 15;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_COUNT_W     = 16;

    localparam logic [7:0] CHAR_NUL  = 8'd0;
    localparam logic [7:0] CHAR_NL   = 8'd10;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    // Line-close information from the line checker to the tally stage.
    typedef struct packed {
        logic emit;     // this character produces a result
        logic present;  // result closes a non-empty line
        logic ok;       // closed line is a valid IMEI
        logic done;     // character was NUL
    } t_close;

    // Allowed second digits for each first digit, bit n = digit n.
    function automatic logic [9:0] prefix_mask(input logic [3:0] first);
        logic [9:0] m;
        case (first)
            4'd0:    m = 10'h002;
            4'd1:    m = 10'h001;
            4'd2:    m = 10'h3FF;
            4'd3:    m = 10'h029;
            4'd4:    m = 10'h230;
            4'd5:    m = 10'h01F;
            4'd6:    m = 10'h3FF;
            4'd7:    m = 10'h3FF;
            4'd8:    m = 10'h040;
            4'd9:    m = 10'h302;
            default: m = 10'h000;
        endcase
        return m;
    endfunction

endpackage

/* rtl/imei_line_check.sv */
// Per-line state: position, Luhn sum, prefix and character checks.
`timescale 1ns / 1ps

module imei_line_check import imei_pkg::*; #(
    parameter int IMEI_DIGITS = IMEI_DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    output t_close     o_close
);

    localparam int POS_W = $clog2(IMEI_DIGITS + 1);
    localparam logic DBL_PARITY = ((IMEI_DIGITS % 2) == 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_too_long, n_too_long;
    logic [3:0]       r_sum, n_sum;
    logic [3:0]       r_first, n_first;
    logic             r_prefix_ok, n_prefix_ok;
    logic             r_bad_char, n_bad_char;
    logic             r_check, n_check;

    logic       is_term;
    logic       is_digit;
    logic [3:0] digit;
    logic [4:0] dbl;
    logic [4:0] add;
    logic [4:0] sum5;
    logic [3:0] sum_wrap;
    logic [3:0] check_digit;
    logic [9:0] mask;
    logic       present;

    always_comb begin
        is_term  = (i_char == CHAR_NUL) || (i_char == CHAR_NL);
        is_digit = i_char inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = 4'(i_char - CHAR_ZERO);
        dbl      = {digit, 1'b0};
        // doubled digit of 10 or more adds its digit sum
        if (r_pos[0] == DBL_PARITY) begin
            add = (dbl >= 5'd10) ? (dbl - 5'd9) : dbl;
        end else begin
            add = {1'b0, digit};
        end
        sum5        = {1'b0, r_sum} + add;
        sum_wrap    = (sum5 >= 5'd10) ? 4'(sum5 - 5'd10) : sum5[3:0];
        check_digit = (r_sum == 4'd0) ? 4'd0 : (4'd10 - r_sum);
        mask        = prefix_mask(r_first);
        present     = (r_pos != '0) || r_too_long;

        o_close.emit    = is_term && (present || (i_char == CHAR_NUL));
        o_close.present = present;
        o_close.ok      = !r_bad_char && !r_too_long && r_prefix_ok && r_check
                          && (r_pos == POS_W'(IMEI_DIGITS));
        o_close.done    = (i_char == CHAR_NUL);

        n_pos       = r_pos;
        n_too_long  = r_too_long;
        n_sum       = r_sum;
        n_first     = r_first;
        n_prefix_ok = r_prefix_ok;
        n_bad_char  = r_bad_char;
        n_check     = r_check;

        if (is_term) begin
            n_pos       = '0;
            n_too_long  = 1'b0;
            n_sum       = 4'd0;
            n_first     = 4'd0;
            n_prefix_ok = 1'b1;
            n_bad_char  = 1'b0;
            n_check     = 1'b0;
        end else if (r_pos >= POS_W'(IMEI_DIGITS)) begin
            n_too_long = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
            if (!is_digit) begin
                n_bad_char = 1'b1;
            end else begin
                if (r_pos == '0) begin
                    n_first = digit;
                end
                if (r_pos == POS_W'(1)) begin
                    n_prefix_ok = mask[digit];
                end
                if (r_pos < POS_W'(IMEI_DIGITS - 1)) begin
                    n_sum = sum_wrap;
                end else begin
                    n_check = (digit == check_digit);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_too_long  <= 1'b0;
            r_sum       <= 4'd0;
            r_first     <= 4'd0;
            r_prefix_ok <= 1'b1;
            r_bad_char  <= 1'b0;
            r_check     <= 1'b0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_too_long  <= n_too_long;
            r_sum       <= n_sum;
            r_first     <= n_first;
            r_prefix_ok <= n_prefix_ok;
            r_bad_char  <= n_bad_char;
            r_check     <= n_check;
        end
    end

endmodule

/* rtl/imei_tally.sv */
// Saturating line counters and the result register.
`timescale 1ns / 1ps

module imei_tally import imei_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_close                 i_close,
    input  logic                   i_out_ready,
    output logic                   o_free,
    output logic                   o_out_valid,
    output logic                   o_line_valid,
    output logic                   o_line_present,
    output logic [OUT_COUNT_W-1:0] o_valid_count,
    output logic [OUT_COUNT_W-1:0] o_invalid_count,
    output logic                   o_text_done
);

    logic [COUNT_WIDTH-1:0] r_valid_total, n_valid_total;
    logic [COUNT_WIDTH-1:0] r_invalid_total, n_invalid_total;
    logic                   r_out_valid;
    logic                   r_line_valid, r_line_present, r_text_done;
    logic [OUT_COUNT_W-1:0] r_valid_count, r_invalid_count;
    logic                   ok;

    assign o_free = !r_out_valid || i_out_ready;

    always_comb begin
        ok              = i_close.present && i_close.ok;
        n_valid_total   = r_valid_total;
        n_invalid_total = r_invalid_total;
        if (i_close.present) begin
            if (ok) begin
                if (!(&r_valid_total)) n_valid_total = r_valid_total + 1'b1;
            end else begin
                if (!(&r_invalid_total)) n_invalid_total = r_invalid_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_total   <= '0;
            r_invalid_total <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid_total   <= n_valid_total;
                r_invalid_total <= n_invalid_total;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_line_valid    <= ok;
            r_line_present  <= i_close.present;
            r_text_done     <= i_close.done;
            r_valid_count   <= OUT_COUNT_W'(n_valid_total);
            r_invalid_count <= OUT_COUNT_W'(n_invalid_total);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_valid    = r_line_valid;
    assign o_line_present  = r_line_present;
    assign o_text_done     = r_text_done;
    assign o_valid_count   = r_valid_count;
    assign o_invalid_count = r_invalid_count;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded while output register busy");

    a_valid_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_valid_total >= $past(r_valid_total)))
        else $error("valid counter decreased");

    a_valid_incr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_close.present && i_close.ok && !(&r_valid_total))
        |=> (r_valid_total == COUNT_WIDTH'($past(r_valid_total) + 1'b1)))
        else $error("valid line not counted");

    a_empty_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_line_present) |-> !r_line_valid)
        else $error("empty line reported valid");

endmodule

/* rtl/imei_stream_validator_core.sv */
// Top level of the IMEI stream validator: input register and flow control.
`timescale 1ns / 1ps

// Takes one text byte per request and checks each non-empty line (ended by
// newline or NUL) as an IMEI: exact length, all digits, reporting-body prefix
// and Luhn check digit. A result request leaves on every non-empty line close
// and on every NUL, carrying saturating valid and invalid line counts. One
// character is accepted every cycle while no result waits on a full result
// register; a closing character passes through the input register, then the
// result register, before its result is presented. The line checker steps
// once per consumed character. When the result register is full and not
// taken, a closing character waits in the input register and input ready
// drops.
module imei_stream_validator_core import imei_pkg::*; #(
    parameter int IMEI_DIGITS = IMEI_DIGITS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_char_code,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_line_valid,
    output logic                   o_line_present,
    output logic [OUT_COUNT_W-1:0] o_valid_count,
    output logic [OUT_COUNT_W-1:0] o_invalid_count,
    output logic                   o_text_done
);

    logic       r_in_valid;
    logic [7:0] r_char;
    t_close     close;
    logic       out_free;
    logic       consume;

    // a character with no result never waits on the output side
    assign consume    = r_in_valid && (!close.emit || out_free);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
        end
    end

    imei_line_check #(
        .IMEI_DIGITS(IMEI_DIGITS)
    ) u_line_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (consume),
        .i_char  (r_char),
        .o_close (close)
    );

    imei_tally #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tally (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (consume && close.emit),
        .i_close         (close),
        .i_out_ready     (i_out_ready),
        .o_free          (out_free),
        .o_out_valid     (o_out_valid),
        .o_line_valid    (o_line_valid),
        .o_line_present  (o_line_present),
        .o_valid_count   (o_valid_count),
        .o_invalid_count (o_invalid_count),
        .o_text_done     (o_text_done)
    );

endmodule
